// ===== src/grdz_pkg.sv =====
package grdz_pkg;

    localparam int FracBits   = 15;
    localparam int RadFrac    = 16;
    localparam int RootSteps  = 4;    // root bits resolved per pipeline stage
    localparam int RootStages = 8;    // 32 root bits of s * 2^32
    localparam int QBits      = FracBits + 1;  // quotient bits per divider
    localparam int QPer       = 4;    // quotient bits per divider stage
    localparam int DivStages  = QBits / QPer;

    localparam logic [14:0] Rim   = 15'd32767;
    localparam logic [31:0] RimSq = 32'd1073676289;   // 32767 squared

    localparam logic [1:0] CfgLeftDz  = 2'd0;
    localparam logic [1:0] CfgRightDz = 2'd1;
    localparam logic [1:0] CfgTrig    = 2'd2;

    // One restoring square root step: partial remainder and root.
    typedef struct packed {
        logic [34:0] rem;
        logic [32:0] root;
        logic [63:0] rad;   // remaining radicand bits, top first
    } sqrt_st_t;

    function automatic sqrt_st_t sqrt_step(sqrt_st_t a);
        logic [36:0] trial;
        logic [36:0] r2;
        sqrt_st_t    o;
        r2    = {a.rem, a.rad[63:62]};
        trial = r2 - {2'b00, a.root, 2'b01};
        o.rad = {a.rad[61:0], 2'b00};
        if (!trial[36]) begin
            o.rem  = trial[34:0];
            o.root = {a.root[31:0], 1'b1};
        end else begin
            o.rem  = r2[34:0];
            o.root = {a.root[31:0], 1'b0};
        end
        return o;
    endfunction

    // One restoring division step: remainder and quotient bit.
    typedef struct packed {
        logic [33:0] rem;
        logic [15:0] quo;
    } div_st_t;

    function automatic div_st_t div_step(div_st_t a, logic [32:0] den);
        logic [34:0] t;
        div_st_t     o;
        t = {a.rem, 1'b0} - {2'b00, den};
        if (!t[34]) begin
            o.rem = t[33:0];
            o.quo = {a.quo[14:0], 1'b1};
        end else begin
            o.rem = {a.rem[32:0], 1'b0};
            o.quo = {a.quo[14:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== src/gamepad_radial_dead_zone.sv =====
// Radial dead zone and trigger threshold normalizer for one gamepad sample.
// Takes one beat per cycle while the output is not stalled; each accepted
// beat passes through the input stage, the radius square root (eight
// stages of four root bits), the divider preload stage, the three stick
// dividers (magnitude and both directions, four stages of four quotient
// bits) and the output register before its result beat is returned.
// A stall on the result side freezes the whole pipeline. The block keeps no
// state besides the three settings registers, which are to be written only
// while no sample is in flight. Results are Q.15 with 32768 standing for
// 1.0, truncated toward zero.
module gamepad_radial_dead_zone
    import grdz_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [14:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lsx[15:0] lsy[31:16] rsx[47:32] rsy[63:48] lt[71:64] rt[79:72]
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // lmag[15:0] ldx[32:16] ldy[49:33] rmag[65:50] rdx[82:66] rdy[99:83]
    // ltrig[115:100] rtrig[131:116], zero filled to 136
    output logic [135:0] m_tdata
);

    localparam int Depth     = 3 + RootStages + DivStages;
    localparam int TrigDelay = Depth - DivStages - 2;

    logic [14:0] ldz_reg, rdz_reg;
    logic [7:0]  trig_reg;

    // Hold settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ldz_reg  <= '0;
            rdz_reg  <= '0;
            trig_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CfgLeftDz:  ldz_reg  <= cfg_data;
                CfgRightDz: rdz_reg  <= cfg_data;
                CfgTrig:    trig_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic [Depth-1:0] vld_reg;
    assign adv      = !vld_reg[Depth-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[Depth-1];

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
        end
    end

    // Per-stick pipeline state
    typedef struct packed {
        logic        sx;
        logic        sy;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [31:0] s;
        logic        pass;
        logic        rim;
        logic [14:0] dz;
    } stk_t;

    // Stage 0 inputs
    logic signed [15:0] cx [2];
    logic signed [15:0] cy [2];
    logic [14:0] dzs [2];
    always_comb begin
        cx[0] = s_tdata[15:0];  cy[0] = s_tdata[31:16];
        cx[1] = s_tdata[47:32]; cy[1] = s_tdata[63:48];
        dzs[0] = ldz_reg;       dzs[1] = rdz_reg;
    end

    genvar k;
    generate
        for (k = 0; k < 2; k++) begin : g_stk
            // Index of the state that lines up with the divider outputs
            localparam int OutIdx = RootStages + 1 + DivStages;

            logic [15:0] axc, ayc;
            logic [31:0] sq, dzsq;
            stk_t        st_reg   [Depth-1];
            sqrt_st_t    sq_reg   [RootStages];
            sqrt_st_t    sq_nx    [RootStages];
            div_st_t     dv_reg   [3][DivStages+1];
            div_st_t     dv_nx    [3][DivStages];
            logic [32:0] dden_reg [3][DivStages];
            logic [32:0] m, base, span;
            logic [32:0] num [3];
            logic [32:0] den [3];
            logic [15:0] mag_o, mag_reg;
            logic [16:0] dx_o, dy_o, dx_reg, dy_reg;

            // Stage 0: squares and dead zone test
            assign axc  = cx[k][15] ? 16'(-cx[k]) : cx[k];
            assign ayc  = cy[k][15] ? 16'(-cy[k]) : cy[k];
            assign sq   = {16'd0, axc} * {16'd0, axc} + {16'd0, ayc} * {16'd0, ayc};
            assign dzsq = {17'd0, dzs[k]} * {17'd0, dzs[k]};

            always_ff @(posedge aclk) begin
                if (adv) begin
                    st_reg[0].sx   <= cx[k][15];
                    st_reg[0].sy   <= cy[k][15];
                    st_reg[0].ax   <= axc;
                    st_reg[0].ay   <= ayc;
                    st_reg[0].s    <= sq;
                    st_reg[0].pass <= sq > dzsq;
                    st_reg[0].rim  <= (sq >= RimSq) || (dzs[k] == Rim);
                    st_reg[0].dz   <= dzs[k];
                    for (int i = 1; i < Depth - 1; i++) begin
                        st_reg[i] <= st_reg[i-1];
                    end
                end
            end

            // Root of s*2^32, four bits per stage
            always_comb begin
                sq_nx[0] = '{rem: '0, root: '0, rad: {st_reg[0].s, 32'd0}};
                for (int i = 0; i < RootSteps; i++) begin
                    sq_nx[0] = sqrt_step(sq_nx[0]);
                end
                for (int d = 1; d < RootStages; d++) begin
                    sq_nx[d] = sq_reg[d-1];
                    for (int i = 0; i < RootSteps; i++) begin
                        sq_nx[d] = sqrt_step(sq_nx[d]);
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int d = 0; d < RootStages; d++) begin
                        sq_reg[d] <= sq_nx[d];
                    end
                end
            end

            // Dividers: 0 magnitude, 1 dir x, 2 dir y.
            // Magnitude is num*2^16/span halved later; directions are
            // (a*2^15)*2^16/m. Each numerator whose quotient is used stays below its divisor.
            always_comb begin
                m    = sq_reg[RootStages-1].root;
                base = {2'b0, st_reg[RootStages].dz, 16'd0};
                span = {2'b0, 15'(Rim - st_reg[RootStages].dz), 16'd0};
                num[0] = (m > base) ? m - base : '0;
                num[1] = {2'b0, st_reg[RootStages].ax, 15'd0};
                num[2] = {2'b0, st_reg[RootStages].ay, 15'd0};
                den[0] = span;
                den[1] = m;
                den[2] = m;
                for (int j = 0; j < 3; j++) begin
                    for (int d = 0; d < DivStages; d++) begin
                        dv_nx[j][d] = dv_reg[j][d];
                        for (int i = 0; i < QPer; i++) begin
                            dv_nx[j][d] = div_step(dv_nx[j][d], dden_reg[j][d]);
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int j = 0; j < 3; j++) begin
                        dv_reg[j][0].rem <= {1'b0, num[j]};
                        dv_reg[j][0].quo <= '0;
                        dden_reg[j][0]   <= den[j];
                        for (int d = 0; d < DivStages; d++) begin
                            dv_reg[j][d+1] <= dv_nx[j][d];
                        end
                        for (int d = 0; d < DivStages - 1; d++) begin
                            dden_reg[j][d+1] <= dden_reg[j][d];
                        end
                    end
                end
            end

            // Output stage: signs, zeroing and the rim cap
            always_comb begin
                if (!st_reg[OutIdx].pass) begin
                    mag_o = '0; dx_o = '0; dy_o = '0;
                end else begin
                    mag_o = st_reg[OutIdx].rim ? 16'd32768
                                               : {1'b0, dv_reg[0][DivStages].quo[15:1]};
                    dx_o  = st_reg[OutIdx].sx ? 17'(-{1'b0, dv_reg[1][DivStages].quo})
                                              : {1'b0, dv_reg[1][DivStages].quo};
                    dy_o  = st_reg[OutIdx].sy ? 17'(-{1'b0, dv_reg[2][DivStages].quo})
                                              : {1'b0, dv_reg[2][DivStages].quo};
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    mag_reg <= mag_o;
                    dx_reg  <= dx_o;
                    dy_reg  <= dy_o;
                end
            end
        end
    endgenerate

    // Triggers: (v-t)*2^15/(255-t) as (v-t)*2^16/(2*(255-t)), then delayed
    logic [7:0] tv [2];
    assign tv[0] = s_tdata[71:64];
    assign tv[1] = s_tdata[79:72];
    generate
        for (k = 0; k < 2; k++) begin : g_trg
            div_st_t     tdv_reg  [DivStages+1];
            div_st_t     tdv_nx   [DivStages];
            logic [8:0]  tden_reg [DivStages];
            logic        tz_reg   [DivStages+1];
            logic [15:0] tq_d_reg [TrigDelay];
            logic [15:0] lvl_reg;

            always_comb begin
                for (int d = 0; d < DivStages; d++) begin
                    tdv_nx[d] = tdv_reg[d];
                    for (int i = 0; i < QPer; i++) begin
                        tdv_nx[d] = div_step(tdv_nx[d], {24'd0, tden_reg[d]});
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    tdv_reg[0].rem <= {26'd0, 8'(tv[k] - trig_reg)};
                    tdv_reg[0].quo <= '0;
                    tden_reg[0]    <= {8'(8'd255 - trig_reg), 1'b0};
                    tz_reg[0]      <= (tv[k] <= trig_reg);
                    for (int d = 0; d < DivStages; d++) begin
                        tdv_reg[d+1] <= tdv_nx[d];
                        tz_reg[d+1]  <= tz_reg[d];
                    end
                    for (int d = 0; d < DivStages - 1; d++) begin
                        tden_reg[d+1] <= tden_reg[d];
                    end
                    // Delay the level to line up with the sticks
                    tq_d_reg[0] <= tz_reg[DivStages] ? 16'd0 : tdv_reg[DivStages].quo;
                    for (int i = 1; i < TrigDelay; i++) begin
                        tq_d_reg[i] <= tq_d_reg[i-1];
                    end
                    lvl_reg <= tq_d_reg[TrigDelay-1];
                end
            end
        end
    endgenerate

    assign m_tdata = {4'd0, g_trg[1].lvl_reg, g_trg[0].lvl_reg,
                      g_stk[1].dy_reg, g_stk[1].dx_reg, g_stk[1].mag_reg,
                      g_stk[0].dy_reg, g_stk[0].dx_reg, g_stk[0].mag_reg};

`ifndef SYNTHESIS
    // Output held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // Left magnitude never exceeds one
    a_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768)
        else $error("left magnitude above one");
    // Ready follows output occupancy
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
`endif

endmodule
